// File: src/pems_pkg.sv
// ----------------------------------------------------------------------------
// pems_pkg: shared types and constants of the message store
// Operation and status codes, severity levels, record layout, item layouts
// and the state encoding of the sequencer.
// ----------------------------------------------------------------------------
package pems_pkg;

  // operation codes (in_tuser)
  localparam logic [2:0] OP_PUSH    = 3'd0;
  localparam logic [2:0] OP_ACK     = 3'd1;
  localparam logic [2:0] OP_ACK_ALL = 3'd2;
  localparam logic [2:0] OP_EXPIRE  = 3'd3;
  localparam logic [2:0] OP_VIEW    = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_PAST_END  = 2'd2;

  // severity levels
  localparam logic [1:0] LVL_INFO = 2'd0;
  localparam logic [1:0] LVL_WARN = 2'd1;
  localparam logic [1:0] LVL_CRIT = 2'd2;

  // longest lifetime: thirty days in seconds
  localparam logic [21:0] TTL_LIMIT = 22'd2592000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ORD,
    S_REC,
    S_EVAL,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_FIN,
    S_DONE
  } state_t;

  // one stored message record
  typedef struct packed {
    logic [31:0] id;
    logic [21:0] ttl;
    logic [31:0] created;
    logic [1:0]  level;
    logic        unread;
    logic [63:0] key;
  } rec_t;

  // input item payload, last field in the lowest bits
  typedef struct packed {
    logic [31:0] now_seconds;
    logic [5:0]  view_index;
    logic [31:0] target_id;
    logic [21:0] ttl_seconds;
    logic [63:0] key_tag;
    logic [1:0]  level;
  } in_t;

  // result item payload, last field in the lowest bits
  typedef struct packed {
    logic        any_unread;
    logic [1:0]  top_unread_level;
    logic [6:0]  unread_count;
    logic [6:0]  queue_count;
    logic [6:0]  changed_count;
    logic [31:0] age_seconds;
    logic        entry_unread;
    logic [1:0]  entry_level;
    logic [5:0]  slot_index;
    logic [31:0] replaced_id;
    logic [31:0] entry_id;
    logic [1:0]  status;
  } res_t;

  // age of a record, zero when the clock is behind its creation
  function automatic logic [31:0] rec_age(rec_t r, logic [31:0] now);
    return (now >= r.created) ? (now - r.created) : 32'd0;
  endfunction

endpackage

// File: src/pems_ram.sv
// ----------------------------------------------------------------------------
// pems_ram: single-port-write, single-port-read synchronous memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pems_ram #(
  parameter int W = 8,
  parameter int D = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/priority_evicting_message_store.sv
// ----------------------------------------------------------------------------
// priority_evicting_message_store: metadata store of messages, newest first
// Each input item is one operation (push, ack, ack all, expire, view); each
// gives exactly one result item with the operation's fields and a summary.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on in_tvalid/in_tready with the operation code in
//   in_tuser; results leave on out_tvalid/out_tready, one per input item.
//   Operations run one at a time. The list order lives in one memory, the
//   records in another, each with one read and one write port and a
//   registered read; visiting one list entry runs through an order read,
//   a record read and an evaluate step.
//   A finished result sits in the output register; the next item is taken
//   while it waits, and the following result waits for it to drain.
//   Reset empties the store at once (per-slot free flags) and sets the id
//   counter to one; no clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_evicting_message_store #(
  parameter int CAPACITY = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // level, key_tag, ttl_seconds, target_id, view_index, now_seconds
  input  logic [159:0] in_tdata,
  // op
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, entry_id, replaced_id, slot_index, entry_level, entry_unread,
  // age_seconds, changed_count, queue_count, unread_count,
  // top_unread_level, any_unread
  output logic [135:0] out_tdata
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  pems_pkg::state_t st_r, st_nxt;

  pems_pkg::in_t in_w;
  assign in_w = pems_pkg::in_t'(in_tdata[157:0]);

  // latched operation
  logic [2:0]  op_r, op_nxt;
  logic [1:0]  lvl_r, lvl_nxt;
  logic [63:0] key_r, key_nxt;
  logic [21:0] ttl_r, ttl_nxt;
  logic [31:0] tgt_r, tgt_nxt;
  logic [31:0] now_r, now_nxt;

  // store state
  logic [CW-1:0]       len_r, len_nxt;
  logic [31:0]         next_id_r, next_id_nxt;
  logic [CAPACITY-1:0] used_r, used_nxt;
  logic [CW-1:0]       unr_cnt_r, unr_cnt_nxt;
  logic [CW-1:0]       lvl_cnt_r [3];
  logic [CW-1:0]       lvl_cnt_nxt [3];

  // scan control
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic [SW-1:0] slot_r, slot_nxt;

  // push candidates
  logic          km_found_r, km_found_nxt;
  logic [CW-1:0] km_pos_r, km_pos_nxt;
  logic [SW-1:0] km_slot_r, km_slot_nxt;
  logic [31:0]   km_id_r, km_id_nxt;
  logic          km_unr_r, km_unr_nxt;
  logic [1:0]    km_lvl_r, km_lvl_nxt;
  logic          rv_found_r, rv_found_nxt;
  logic [CW-1:0] rv_pos_r, rv_pos_nxt;
  logic [SW-1:0] rv_slot_r, rv_slot_nxt;
  logic          nv_found_r, nv_found_nxt;
  logic [CW-1:0] nv_pos_r, nv_pos_nxt;
  logic [SW-1:0] nv_slot_r, nv_slot_nxt;
  logic [1:0]    nv_lvl_r, nv_lvl_nxt;
  logic [SW-1:0] ov_slot_r, ov_slot_nxt;
  logic          free_found_r, free_found_nxt;
  logic [SW-1:0] free_slot_r, free_slot_nxt;
  logic [SW-1:0] free_k_r, free_k_nxt;
  logic          drop_r, drop_nxt;
  logic [SW-1:0] new_slot_r, new_slot_nxt;

  // result fields
  logic [1:0]    stat_r, stat_nxt;
  logic [31:0]   eid_r, eid_nxt;
  logic [31:0]   rid_r, rid_nxt;
  logic [SW-1:0] oslot_r, oslot_nxt;
  logic [1:0]    elev_r, elev_nxt;
  logic          eunr_r, eunr_nxt;
  logic [31:0]   age_r, age_nxt;
  logic [CW-1:0] chg_r, chg_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  pems_pkg::res_t    res_r, res_nxt;

  // memories
  logic               ord_we, rec_we;
  logic [SW-1:0]      ord_waddr, ord_raddr, ord_wdata, ord_rdata;
  logic [SW-1:0]      rec_waddr, rec_raddr;
  pems_pkg::rec_t     rec_wdata, rec_rdata;
  logic [$bits(pems_pkg::rec_t)-1:0] rec_rword;

  pems_ram #(.W(SW), .D(CAPACITY)) u_order (
    .clk  (clk),
    .we   (ord_we),
    .waddr(ord_waddr),
    .wdata(ord_wdata),
    .raddr(ord_raddr),
    .rdata(ord_rdata)
  );

  pems_ram #(.W($bits(pems_pkg::rec_t)), .D(CAPACITY)) u_records (
    .clk  (clk),
    .we   (rec_we),
    .waddr(rec_waddr),
    .wdata(rec_wdata),
    .raddr(rec_raddr),
    .rdata(rec_rword)
  );
  assign rec_rdata = pems_pkg::rec_t'(rec_rword);

  // shared conditions
  logic full_w, last_up_w, ready_done_w, accept_w, expire_hit_w;
  logic [31:0] age_w;
  assign full_w       = (len_r == CAP_C);
  assign last_up_w    = (pos_r == len_r - ONE_C);
  assign ready_done_w = !out_valid_r || out_tready;
  assign in_tready    = (st_r == pems_pkg::S_IDLE);
  assign accept_w     = in_tvalid && in_tready;
  assign age_w        = pems_pkg::rec_age(rec_rdata, now_r);
  assign expire_hit_w = (rec_rdata.ttl != 22'd0)
                     && !(rec_rdata.unread && rec_rdata.level == pems_pkg::LVL_CRIT)
                     && (age_w >= {10'd0, rec_rdata.ttl});

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      pems_pkg::S_IDLE: begin
        if (accept_w) begin
          case (in_tuser)
            pems_pkg::OP_PUSH: begin
              st_nxt = (len_r == '0) ? pems_pkg::S_DECIDE : pems_pkg::S_ORD;
            end
            pems_pkg::OP_ACK, pems_pkg::OP_ACK_ALL, pems_pkg::OP_EXPIRE: begin
              st_nxt = (len_r == '0) ? pems_pkg::S_DONE : pems_pkg::S_ORD;
            end
            pems_pkg::OP_VIEW: begin
              st_nxt = ({1'b0, in_w.view_index} >= 7'(len_r)) ? pems_pkg::S_DONE
                                                                : pems_pkg::S_ORD;
            end
            default: st_nxt = pems_pkg::S_DONE;
          endcase
        end
      end
      pems_pkg::S_ORD: st_nxt = pems_pkg::S_REC;
      pems_pkg::S_REC: st_nxt = pems_pkg::S_EVAL;
      pems_pkg::S_EVAL: begin
        case (op_r)
          pems_pkg::OP_PUSH: begin
            st_nxt = (pos_r == '0) ? pems_pkg::S_DECIDE : pems_pkg::S_ORD;
          end
          pems_pkg::OP_ACK: begin
            st_nxt = (rec_rdata.id == tgt_r || last_up_w) ? pems_pkg::S_DONE
                                                          : pems_pkg::S_ORD;
          end
          pems_pkg::OP_VIEW: st_nxt = pems_pkg::S_DONE;
          default: st_nxt = last_up_w ? pems_pkg::S_DONE : pems_pkg::S_ORD;
        endcase
      end
      pems_pkg::S_DECIDE: begin
        if (full_w || free_found_r) begin
          st_nxt = pems_pkg::S_SH_RD;
        end
      end
      pems_pkg::S_SH_RD: st_nxt = (pos_r == '0) ? pems_pkg::S_FIN : pems_pkg::S_SH_WR;
      pems_pkg::S_SH_WR: st_nxt = pems_pkg::S_SH_RD;
      pems_pkg::S_FIN:   st_nxt = pems_pkg::S_DONE;
      pems_pkg::S_DONE: begin
        if (ready_done_w) begin
          st_nxt = pems_pkg::S_IDLE;
        end
      end
      default: st_nxt = pems_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    logic          dec_en, inc_en, clr_cnt;
    logic [1:0]    dec_lvl, inc_lvl;
    logic          drop_v;
    logic [CW-1:0] dp_v;
    logic [SW-1:0] ds_v, s_v;
    logic [31:0]   cur_id, nx_id;
    logic [1:0]    top_v;

    op_nxt = op_r;   lvl_nxt = lvl_r;   key_nxt = key_r;   ttl_nxt = ttl_r;
    tgt_nxt = tgt_r; now_nxt = now_r;
    len_nxt = len_r; next_id_nxt = next_id_r; used_nxt = used_r;
    pos_nxt = pos_r; wr_nxt = wr_r; slot_nxt = slot_r;
    km_found_nxt = km_found_r; km_pos_nxt = km_pos_r; km_slot_nxt = km_slot_r;
    km_id_nxt = km_id_r; km_unr_nxt = km_unr_r; km_lvl_nxt = km_lvl_r;
    rv_found_nxt = rv_found_r; rv_pos_nxt = rv_pos_r; rv_slot_nxt = rv_slot_r;
    nv_found_nxt = nv_found_r; nv_pos_nxt = nv_pos_r; nv_slot_nxt = nv_slot_r;
    nv_lvl_nxt = nv_lvl_r; ov_slot_nxt = ov_slot_r;
    free_found_nxt = free_found_r; free_slot_nxt = free_slot_r; free_k_nxt = free_k_r;
    drop_nxt = drop_r; new_slot_nxt = new_slot_r;
    stat_nxt = stat_r; eid_nxt = eid_r; rid_nxt = rid_r; oslot_nxt = oslot_r;
    elev_nxt = elev_r; eunr_nxt = eunr_r; age_nxt = age_r; chg_nxt = chg_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r && !out_tready;

    ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0; ord_raddr = '0;
    rec_we = 1'b0; rec_waddr = '0; rec_wdata = rec_rdata; rec_raddr = '0;

    dec_en = 1'b0; dec_lvl = pems_pkg::LVL_INFO;
    inc_en = 1'b0; inc_lvl = pems_pkg::LVL_INFO;
    clr_cnt = 1'b0;
    top_v = pems_pkg::LVL_INFO;
    drop_v = 1'b0; dp_v = len_r; ds_v = '0; s_v = free_slot_r;
    cur_id = (next_id_r == 32'd0) ? 32'd1 : next_id_r;
    nx_id  = cur_id + 32'd1;
    if (nx_id == 32'd0) begin
      nx_id = 32'd1;
    end

    // lowest free slot search, runs beside the push scan
    if (op_r == pems_pkg::OP_PUSH && !free_found_r && !full_w
        && (st_r == pems_pkg::S_ORD || st_r == pems_pkg::S_REC
            || st_r == pems_pkg::S_EVAL || st_r == pems_pkg::S_DECIDE)) begin
      if (!used_r[free_k_r]) begin
        free_found_nxt = 1'b1;
        free_slot_nxt  = free_k_r;
      end else begin
        free_k_nxt = free_k_r + SW'(1);
      end
    end

    case (st_r)
      // latch the item and set up the scan
      pems_pkg::S_IDLE: begin
        if (accept_w) begin
          op_nxt   = in_tuser;
          lvl_nxt  = (in_w.level > pems_pkg::LVL_CRIT) ? pems_pkg::LVL_INFO : in_w.level;
          ttl_nxt  = (in_w.ttl_seconds > pems_pkg::TTL_LIMIT) ? pems_pkg::TTL_LIMIT
                                                              : in_w.ttl_seconds;
          key_nxt  = in_w.key_tag;
          tgt_nxt  = in_w.target_id;
          now_nxt  = in_w.now_seconds;
          km_found_nxt = 1'b0; rv_found_nxt = 1'b0; nv_found_nxt = 1'b0;
          free_found_nxt = 1'b0; free_k_nxt = '0;
          stat_nxt = (in_tuser == pems_pkg::OP_ACK) ? pems_pkg::ST_NOT_FOUND
                                                     : pems_pkg::ST_OK;
          eid_nxt = '0; rid_nxt = '0; oslot_nxt = '0; elev_nxt = '0;
          eunr_nxt = 1'b0; age_nxt = '0; chg_nxt = '0;
          wr_nxt = '0;
          case (in_tuser)
            pems_pkg::OP_PUSH: pos_nxt = len_r - ONE_C;
            pems_pkg::OP_VIEW: begin
              pos_nxt = CW'(in_w.view_index);
              if ({1'b0, in_w.view_index} >= 7'(len_r)) begin
                stat_nxt = pems_pkg::ST_PAST_END;
              end
            end
            default: pos_nxt = '0;
          endcase
        end
      end
      pems_pkg::S_ORD: begin
        ord_raddr = pos_r[SW-1:0];
      end
      pems_pkg::S_REC: begin
        slot_nxt  = ord_rdata;
        rec_raddr = ord_rdata;
      end
      // evaluate one list entry
      pems_pkg::S_EVAL: begin
        case (op_r)
          pems_pkg::OP_PUSH: begin
            if (key_r != 64'd0 && !km_found_r && rec_rdata.key == key_r) begin
              km_found_nxt = 1'b1; km_pos_nxt = pos_r; km_slot_nxt = slot_r;
              km_id_nxt = rec_rdata.id; km_unr_nxt = rec_rdata.unread;
              km_lvl_nxt = rec_rdata.level;
            end
            if (!rv_found_r && !rec_rdata.unread) begin
              rv_found_nxt = 1'b1; rv_pos_nxt = pos_r; rv_slot_nxt = slot_r;
            end
            if (!nv_found_r && rec_rdata.level != pems_pkg::LVL_CRIT) begin
              nv_found_nxt = 1'b1; nv_pos_nxt = pos_r; nv_slot_nxt = slot_r;
              nv_lvl_nxt = rec_rdata.level;
            end
            if (last_up_w) begin
              ov_slot_nxt = slot_r;
            end
            pos_nxt = pos_r - ONE_C;
          end
          pems_pkg::OP_ACK: begin
            if (rec_rdata.id == tgt_r) begin
              rec_we = 1'b1; rec_waddr = slot_r;
              rec_wdata = rec_rdata; rec_wdata.unread = 1'b0;
              stat_nxt = pems_pkg::ST_OK;
              dec_en = rec_rdata.unread; dec_lvl = rec_rdata.level;
            end
            pos_nxt = pos_r + ONE_C;
          end
          pems_pkg::OP_ACK_ALL: begin
            if (rec_rdata.unread) begin
              rec_we = 1'b1; rec_waddr = slot_r;
              rec_wdata = rec_rdata; rec_wdata.unread = 1'b0;
            end
            if (last_up_w) begin
              chg_nxt = unr_cnt_r;
              clr_cnt = 1'b1;
            end
            pos_nxt = pos_r + ONE_C;
          end
          pems_pkg::OP_EXPIRE: begin
            if (expire_hit_w) begin
              used_nxt[slot_r] = 1'b0;
              chg_nxt = chg_r + ONE_C;
              dec_en = rec_rdata.unread; dec_lvl = rec_rdata.level;
            end else begin
              ord_we = 1'b1; ord_waddr = wr_r[SW-1:0]; ord_wdata = slot_r;
              wr_nxt = wr_r + ONE_C;
            end
            if (last_up_w) begin
              len_nxt = expire_hit_w ? wr_r : (wr_r + ONE_C);
            end
            pos_nxt = pos_r + ONE_C;
          end
          pems_pkg::OP_VIEW: begin
            eid_nxt = rec_rdata.id; oslot_nxt = slot_r;
            elev_nxt = rec_rdata.level; eunr_nxt = rec_rdata.unread;
            age_nxt = age_w;
          end
          default: ;
        endcase
      end
      // pick the entry to drop and the slot to fill
      pems_pkg::S_DECIDE: begin
        if (full_w || free_found_r) begin
          if (km_found_r) begin
            drop_v = 1'b1; dp_v = km_pos_r; ds_v = km_slot_r;
            dec_en = km_unr_r; dec_lvl = km_lvl_r;
            rid_nxt = km_id_r;
          end else if (full_w) begin
            drop_v = 1'b1;
            if (rv_found_r) begin
              dp_v = rv_pos_r; ds_v = rv_slot_r;
            end else if (nv_found_r) begin
              dp_v = nv_pos_r; ds_v = nv_slot_r;
              dec_en = 1'b1; dec_lvl = nv_lvl_r;
            end else begin
              dp_v = len_r - ONE_C; ds_v = ov_slot_r;
              dec_en = 1'b1; dec_lvl = pems_pkg::LVL_CRIT;
            end
          end
          if (drop_v) begin
            used_nxt[ds_v] = 1'b0;
            if (full_w || ds_v < free_slot_r) begin
              s_v = ds_v;
            end
          end
          drop_nxt = drop_v;
          new_slot_nxt = s_v;
          pos_nxt = dp_v;
        end
      end
      // move entries ahead of the dropped one back by one place
      pems_pkg::S_SH_RD: begin
        ord_raddr = pos_r[SW-1:0] - SW'(1);
      end
      pems_pkg::S_SH_WR: begin
        ord_we = 1'b1; ord_waddr = pos_r[SW-1:0]; ord_wdata = ord_rdata;
        pos_nxt = pos_r - ONE_C;
      end
      // place the new entry in front
      pems_pkg::S_FIN: begin
        ord_we = 1'b1; ord_waddr = '0; ord_wdata = new_slot_r;
        rec_we = 1'b1; rec_waddr = new_slot_r;
        rec_wdata.id = cur_id;  rec_wdata.ttl = ttl_r; rec_wdata.created = now_r;
        rec_wdata.level = lvl_r; rec_wdata.unread = 1'b1; rec_wdata.key = key_r;
        used_nxt[new_slot_r] = 1'b1;
        len_nxt = len_r - (drop_r ? ONE_C : '0) + ONE_C;
        inc_en = 1'b1; inc_lvl = lvl_r;
        eid_nxt = cur_id; oslot_nxt = new_slot_r;
        next_id_nxt = nx_id;
      end
      // hand the result to the output register
      pems_pkg::S_DONE: begin
        if (ready_done_w) begin
          if (lvl_cnt_r[2] != '0) begin
            top_v = pems_pkg::LVL_CRIT;
          end else if (lvl_cnt_r[1] != '0) begin
            top_v = pems_pkg::LVL_WARN;
          end else begin
            top_v = pems_pkg::LVL_INFO;
          end
          res_nxt.status           = stat_r;
          res_nxt.entry_id         = eid_r;
          res_nxt.replaced_id      = rid_r;
          res_nxt.slot_index       = 6'(oslot_r);
          res_nxt.entry_level      = elev_r;
          res_nxt.entry_unread     = eunr_r;
          res_nxt.age_seconds      = age_r;
          res_nxt.changed_count    = 7'(chg_r);
          res_nxt.queue_count      = 7'(len_r);
          res_nxt.unread_count     = 7'(unr_cnt_r);
          res_nxt.top_unread_level = top_v;
          res_nxt.any_unread       = (unr_cnt_r != '0);
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    // unread bookkeeping
    unr_cnt_nxt = unr_cnt_r - (dec_en ? ONE_C : '0) + (inc_en ? ONE_C : '0);
    for (int k = 0; k < 3; k++) begin
      lvl_cnt_nxt[k] = lvl_cnt_r[k]
                     - ((dec_en && dec_lvl == 2'(k)) ? ONE_C : '0)
                     + ((inc_en && inc_lvl == 2'(k)) ? ONE_C : '0);
    end
    if (clr_cnt) begin
      unr_cnt_nxt = '0;
      for (int k = 0; k < 3; k++) begin
        lvl_cnt_nxt[k] = '0;
      end
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= pems_pkg::S_IDLE;
      len_r       <= '0;
      next_id_r   <= 32'd1;
      used_r      <= '0;
      unr_cnt_r   <= '0;
      for (int k = 0; k < 3; k++) begin
        lvl_cnt_r[k] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      len_r       <= len_nxt;
      next_id_r   <= next_id_nxt;
      used_r      <= used_nxt;
      unr_cnt_r   <= unr_cnt_nxt;
      for (int k = 0; k < 3; k++) begin
        lvl_cnt_r[k] <= lvl_cnt_nxt[k];
      end
      out_valid_r <= out_valid_nxt;
    end
    op_r <= op_nxt;   lvl_r <= lvl_nxt;   key_r <= key_nxt;   ttl_r <= ttl_nxt;
    tgt_r <= tgt_nxt; now_r <= now_nxt;
    pos_r <= pos_nxt; wr_r <= wr_nxt; slot_r <= slot_nxt;
    km_found_r <= km_found_nxt; km_pos_r <= km_pos_nxt; km_slot_r <= km_slot_nxt;
    km_id_r <= km_id_nxt; km_unr_r <= km_unr_nxt; km_lvl_r <= km_lvl_nxt;
    rv_found_r <= rv_found_nxt; rv_pos_r <= rv_pos_nxt; rv_slot_r <= rv_slot_nxt;
    nv_found_r <= nv_found_nxt; nv_pos_r <= nv_pos_nxt; nv_slot_r <= nv_slot_nxt;
    nv_lvl_r <= nv_lvl_nxt; ov_slot_r <= ov_slot_nxt;
    free_found_r <= free_found_nxt; free_slot_r <= free_slot_nxt; free_k_r <= free_k_nxt;
    drop_r <= drop_nxt; new_slot_r <= new_slot_nxt;
    stat_r <= stat_nxt; eid_r <= eid_nxt; rid_r <= rid_nxt; oslot_r <= oslot_nxt;
    elev_r <= elev_nxt; eunr_r <= eunr_nxt; age_r <= age_nxt; chg_r <= chg_nxt;
    res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r};

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CAP_C)
    else $error("list length beyond capacity");

  a_unread_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == pems_pkg::S_IDLE) |->
      ((CW+2)'(lvl_cnt_r[0]) + (CW+2)'(lvl_cnt_r[1]) + (CW+2)'(lvl_cnt_r[2])
       == (CW+2)'(unr_cnt_r)))
    else $error("per-level unread counts disagree with unread total");

  a_unread_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == pems_pkg::S_IDLE) |-> (unr_cnt_r <= len_r))
    else $error("more unread entries than held entries");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (st_r != pems_pkg::S_IDLE))
    else $error("accepted item left the sequencer idle");
`endif

endmodule
